/* hw/rtl/jmsp_pkg.sv */
`default_nettype none

package jmsp_pkg;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_SOI0    = 4'd0,
        PH_SOI1    = 4'd1,
        PH_MARK0   = 4'd2,
        PH_MARK1   = 4'd3,
        PH_LENHI   = 4'd4,
        PH_LENLO   = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_SCAN    = 4'd7,
        PH_SCANFF  = 4'd8,
        PH_IDLE    = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_PAYLOAD = 3'd1,
        KIND_ENTROPY = 3'd2,
        KIND_RESTART = 3'd3,
        KIND_EOI     = 3'd4,
        KIND_ERROR   = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_BAD_SOI  = 3'd1,
        ERR_NO_FF    = 3'd2,
        ERR_PROGRESS = 3'd3,
        ERR_UNSUP    = 3'd4
    } t_err;

    typedef enum logic [1:0] {
        SC_FWD   = 2'd0,
        SC_DROP  = 2'd1,
        SC_PROG  = 2'd2,
        SC_UNSUP = 2'd3
    } t_seg_class;

    localparam logic [7:0] MK_PREFIX = 8'hff;
    localparam logic [7:0] MK_SOI    = 8'hd8;
    localparam logic [7:0] MK_EOI    = 8'hd9;
    localparam logic [7:0] MK_SOS    = 8'hda;
    localparam logic [7:0] MK_RST0   = 8'hd0;
    localparam logic [7:0] MK_RST7   = 8'hd7;
    localparam logic [7:0] MK_COM    = 8'hfe;
    localparam logic [7:0] MK_APP0   = 8'he0;
    localparam logic [7:0] MK_APP15  = 8'hef;
    localparam logic [7:0] MK_DQT    = 8'hdb;
    localparam logic [7:0] MK_SOF0   = 8'hc0;
    localparam logic [7:0] MK_DHT    = 8'hc4;
    localparam logic [7:0] MK_SOF2   = 8'hc2;
    localparam logic [7:0] STUFF     = 8'h00;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_file;
    } t_in_beat;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_value;
        logic [7:0]  segment_code;
        logic [15:0] payload_index;
        logic        segment_last;
        t_err        error_code;
    } t_out_beat;

    function automatic t_seg_class classify(input logic [7:0] code);
        t_seg_class cls;
        if ((code >= MK_APP0 && code <= MK_APP15) || code == MK_COM) begin
            cls = SC_DROP;
        end else if (code == MK_DQT || code == MK_SOF0 || code == MK_SOS
                     || code == MK_DHT) begin
            cls = SC_FWD;
        end else if (code == MK_SOF2) begin
            cls = SC_PROG;
        end else begin
            cls = SC_UNSUP;
        end
        return cls;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/jmsp_out_buf.sv */
`default_nettype none

module jmsp_out_buf
    import jmsp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_beat i_push_beat,
    output logic           o_can_push,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_beat
);

    // Main output register plus one skid entry, so the upstream side may
    // push in the cycle in which a result is still waiting downstream.
    logic      r_main_valid;
    logic      r_skid_valid;
    t_out_beat r_main;
    t_out_beat r_skid;
    logic      pop;

    assign pop         = r_main_valid && i_out_ready;
    assign o_can_push  = !r_skid_valid;
    assign o_out_valid = r_main_valid;
    assign o_out_beat  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            if (!r_main_valid) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (i_push) begin
                r_main <= i_push_beat;
            end
        end else if (i_push) begin
            if (!r_main_valid) begin
                r_main <= i_push_beat;
            end else begin
                r_skid <= i_push_beat;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/jpeg_marker_stream_parser.sv */
`default_nettype none

// JPEG marker stream parser. The block takes a JPEG file one byte per input
// beat and returns exactly one result beat for every byte, in order. It
// checks the SOI marker, then walks the marker segments (FF, marker code,
// 16-bit big-endian length, payload). Payload bytes of DQT, SOF0, SOS and
// DHT are forwarded with their position and a last flag; APPn and COM
// payload is dropped; SOF2 and any other code raise an error when the
// segment ends. After SOS the entropy-coded bytes are unstuffed and restart
// markers are reported; any other marker ends the scan. EOI ends the image,
// and after an error or EOI bytes yield empty results until new_file marks
// the first byte of a new file. Throughput is one byte per clock cycle:
// the parser state is updated in a single pass when a beat is accepted,
// and the result is registered into a two-entry output buffer, so input
// ready only drops while both buffer entries are occupied.
module jpeg_marker_stream_parser
    import jmsp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in_beat,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_beat
);

    // Parser state.
    t_phase     r_phase;
    logic [7:0] r_marker;
    logic [15:0] r_bytes_left;
    logic [15:0] r_byte_pos;
    logic [7:0] r_len_high;
    t_seg_class r_class;

    t_phase     n_phase;
    logic [7:0] n_marker;
    logic [15:0] n_bytes_left;
    logic [15:0] n_byte_pos;
    logic [7:0] n_len_high;
    t_seg_class n_class;

    // State as seen by the current byte: a new file clears everything first.
    t_phase     cur_phase;
    logic [7:0] cur_marker;
    logic [15:0] cur_bytes_left;
    logic [15:0] cur_byte_pos;
    logic [7:0] cur_len_high;
    t_seg_class cur_class;

    logic [7:0]  in_byte;
    logic        accept;
    logic        can_push;
    logic [15:0] seg_len;
    logic [15:0] left_dec;
    logic        class_bad;
    t_phase      seg_end_phase;
    t_err        seg_end_err;
    t_out_beat   res;

    assign in_byte    = i_in_beat.data_byte;
    assign o_in_ready = can_push;
    assign accept     = i_in_valid && can_push;

    always_comb begin
        if (i_in_beat.new_file) begin
            cur_phase      = PH_SOI0;
            cur_marker     = 8'h00;
            cur_bytes_left = 16'd0;
            cur_byte_pos   = 16'd0;
            cur_len_high   = 8'h00;
            cur_class      = SC_FWD;
        end else begin
            cur_phase      = r_phase;
            cur_marker     = r_marker;
            cur_bytes_left = r_bytes_left;
            cur_byte_pos   = r_byte_pos;
            cur_len_high   = r_len_high;
            cur_class      = r_class;
        end
    end

    assign seg_len  = {cur_len_high, in_byte};
    assign left_dec = cur_bytes_left - 16'd1;

    // Where a finished segment leads: a progressive or unsupported segment
    // is reported as an error, otherwise the scan or the next marker follows.
    assign class_bad = (cur_class == SC_PROG) || (cur_class == SC_UNSUP);
    always_comb begin
        if (class_bad) begin
            seg_end_phase = PH_IDLE;
        end else if (cur_marker == MK_SOS) begin
            seg_end_phase = PH_SCAN;
        end else begin
            seg_end_phase = PH_MARK0;
        end
        seg_end_err = (cur_class == SC_PROG) ? ERR_PROGRESS : ERR_UNSUP;
    end

    // Next-state logic.
    always_comb begin
        n_phase      = cur_phase;
        n_marker     = cur_marker;
        n_bytes_left = cur_bytes_left;
        n_byte_pos   = cur_byte_pos;
        n_len_high   = cur_len_high;
        n_class      = cur_class;
        unique case (cur_phase)
            PH_SOI0: begin
                n_phase = (in_byte == MK_PREFIX) ? PH_SOI1 : PH_IDLE;
            end
            PH_SOI1: begin
                n_phase = (in_byte == MK_SOI) ? PH_MARK0 : PH_IDLE;
            end
            PH_MARK0: begin
                n_phase = (in_byte == MK_PREFIX) ? PH_MARK1 : PH_IDLE;
            end
            PH_MARK1: begin
                n_marker = in_byte;
                if (in_byte == MK_EOI) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_class = classify(in_byte);
                    n_phase = PH_LENHI;
                end
            end
            PH_LENHI: begin
                n_len_high = in_byte;
                n_phase    = PH_LENLO;
            end
            PH_LENLO: begin
                n_byte_pos = 16'd0;
                if (seg_len < 16'd2) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_bytes_left = seg_len - 16'd2;
                    n_phase = (seg_len == 16'd2) ? seg_end_phase : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_byte_pos   = cur_byte_pos + 16'd1;
                n_bytes_left = left_dec;
                if (left_dec == 16'd0) begin
                    n_phase = seg_end_phase;
                end
            end
            PH_SCAN: begin
                if (in_byte == MK_PREFIX) begin
                    n_phase = PH_SCANFF;
                end
            end
            PH_SCANFF: begin
                if (in_byte == STUFF) begin
                    n_phase = PH_SCAN;
                end else if (in_byte >= MK_RST0 && in_byte <= MK_RST7) begin
                    n_phase = PH_SCAN;
                end else begin
                    // Any other marker ends the scan and starts a segment.
                    n_marker = in_byte;
                    if (in_byte == MK_EOI) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_class = classify(in_byte);
                        n_phase = PH_LENHI;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Result logic.
    always_comb begin
        res               = '0;
        res.kind          = KIND_NONE;
        res.error_code    = ERR_NONE;
        res.segment_code  = n_marker;
        unique case (cur_phase)
            PH_SOI0: begin
                if (in_byte != MK_PREFIX) begin
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_BAD_SOI;
                end
            end
            PH_SOI1: begin
                if (in_byte != MK_SOI) begin
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_BAD_SOI;
                end
            end
            PH_MARK0: begin
                if (in_byte != MK_PREFIX) begin
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_NO_FF;
                end
            end
            PH_MARK1: begin
                if (in_byte == MK_EOI) begin
                    res.kind = KIND_EOI;
                end
            end
            PH_LENLO: begin
                if (seg_len < 16'd2) begin
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_UNSUP;
                end else if (seg_len == 16'd2 && class_bad) begin
                    res.kind       = KIND_ERROR;
                    res.error_code = seg_end_err;
                end
            end
            PH_PAYLOAD: begin
                if (cur_class == SC_FWD) begin
                    res.kind          = KIND_PAYLOAD;
                    res.data_value    = in_byte;
                    res.payload_index = cur_byte_pos;
                    res.segment_last  = (cur_bytes_left <= 16'd1)
                                        || (left_dec == 16'd0);
                end else if (left_dec == 16'd0 && class_bad) begin
                    res.kind       = KIND_ERROR;
                    res.error_code = seg_end_err;
                end
            end
            PH_SCAN: begin
                if (in_byte != MK_PREFIX) begin
                    res.kind       = KIND_ENTROPY;
                    res.data_value = in_byte;
                end
            end
            PH_SCANFF: begin
                if (in_byte == STUFF) begin
                    res.kind       = KIND_ENTROPY;
                    res.data_value = MK_PREFIX;
                end else if (in_byte >= MK_RST0 && in_byte <= MK_RST7) begin
                    res.kind       = KIND_RESTART;
                    res.data_value = {5'd0, in_byte[2:0]};
                end else if (in_byte == MK_EOI) begin
                    res.kind = KIND_EOI;
                end
            end
            default: begin
                res.kind = KIND_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SOI0;
            r_marker     <= 8'h00;
            r_bytes_left <= 16'd0;
            r_byte_pos   <= 16'd0;
            r_len_high   <= 8'h00;
            r_class      <= SC_FWD;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_marker     <= n_marker;
            r_bytes_left <= n_bytes_left;
            r_byte_pos   <= n_byte_pos;
            r_len_high   <= n_len_high;
            r_class      <= n_class;
        end
    end

    jmsp_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_push_beat (res),
        .o_can_push  (can_push),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

endmodule

`default_nettype wire
